// ===== design/zbp_pkg.sv =====
// Shared types, constants and codes for the z-buffered Blinn-Phong shader.
package zbp_pkg;

  localparam int FRAME_WIDTH_DEF  = 1024;
  localparam int FRAME_HEIGHT_DEF = 768;

  localparam logic [23:0] DEPTH_FAR    = 24'hFFFFFF;
  localparam logic [7:0]  ALPHA_BYTE   = 8'hFF;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF000000;
  localparam logic [15:0] LIGHT_RESET  = 16'd9459;

  localparam int ONE14      = 16384;
  localparam int HALF14     = 8192;
  localparam int W_DIFFUSE  = 9830;
  localparam int W_SPECULAR = 6554;

  // sequencer limits
  localparam logic [1:0] LANE_LAST = 2'd2;
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_TOP   = 5'd17;
  localparam logic [4:0] POW_LAST  = 5'd7;
  localparam logic [4:0] POW_P2    = 5'd1;
  localparam logic [4:0] POW_P16   = 5'd4;
  localparam logic [4:0] POW_M16   = 5'd6;
  localparam logic [4:0] POW_M2    = 5'd7;

  // shade modes; any other code shades flat
  localparam logic [1:0] MODE_LIT    = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;

  // register indexes
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_LX   = 2'd1;
  localparam logic [1:0] REG_LY   = 2'd2;
  localparam logic [1:0] REG_LZ   = 2'd3;

  // vector being normalized
  localparam logic [1:0] PASS_OBJ  = 2'd0;
  localparam logic [1:0] PASS_EYE  = 2'd1;
  localparam logic [1:0] PASS_HALF = 2'd2;

  // kind of result word
  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_CLEAR = 2'd1;
  localparam logic [1:0] RES_COLOR = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADDR,
    OP_SEL,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_FIN,
    OP_NSTORE,
    OP_DOT,
    OP_DOTH,
    OP_POW,
    OP_INT0,
    OP_INT1,
    OP_COLOR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] lane;
    logic [4:0] step;
    logic [1:0] pass;
    logic [1:0] res;
    logic       emit;
    logic       drd;
    logic       dwr;
  } cmd_t;

  typedef struct packed {
    logic       in_frame;
    logic       is_clear;
    logic       depth_pass;
    logic       dot_pos;
    logic       out_free;
    logic [1:0] mode;
  } sts_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] lz;
  } cfg_t;

endpackage

// ===== design/zbuffered_blinn_phong_fragment_shader.sv =====
// Top level: config registers, depth store, sequencer and datapath.
//
//   port group   direction   handshake          carries
//   in_*         input       in_valid/in_ready  one fragment or pixel clear
//   out_*        output      out_valid/out_ready one color write word
//   APB          input       psel/penable       shade mode, light direction
//
// Lit mode normalizes three vectors (two when the light faces away), each by
// a 32-step square root and three 18-step divides. Normal mode normalizes two,
// flat mode none; clears, depth rejects and off-frame pixels go straight to the output word.
// After reset the store is swept to far plane, all FRAME_WIDTH*FRAME_HEIGHT words
// (786432 by default), with in_ready low. A new fragment is taken while the last
// word waits on out_ready; in_ready is high only while the sequencer is idle.
module zbuffered_blinn_phong_fragment_shader #(
  parameter int FRAME_WIDTH  = zbp_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = zbp_pkg::FRAME_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [9:0]         in_pixel_x,
  input  logic [9:0]         in_pixel_y,
  input  logic [23:0]        in_frag_depth,
  input  logic [23:0]        in_recip_w,
  input  logic signed [23:0] in_attr_0,
  input  logic signed [23:0] in_attr_1,
  input  logic signed [23:0] in_attr_2,
  input  logic signed [23:0] in_attr_3,
  input  logic signed [23:0] in_attr_4,
  input  logic signed [23:0] in_attr_5,
  input  logic               in_front_facing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_pixel_write,
  output logic [9:0]         out_x,
  output logic [9:0]         out_row,
  output logic [31:0]        out_argb_color,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [1:0]         mode_r;
  logic signed [15:0] lx_r, ly_r, lz_r;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  zbp_pkg::cfg_t      cfg;
  zbp_pkg::cmd_t      cmd;
  zbp_pkg::sts_t      sts;
  logic               clr_active;
  logic [AW-1:0]      clr_addr, dp_addr, ram_waddr;
  logic [23:0]        dp_wdata, ram_wdata, ram_rdata;
  logic               ram_we;
  logic signed [23:0] attr_w [6];

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= zbp_pkg::MODE_LIT;
      lx_r   <= zbp_pkg::LIGHT_RESET;
      ly_r   <= zbp_pkg::LIGHT_RESET;
      lz_r   <= zbp_pkg::LIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        zbp_pkg::REG_MODE: mode_r <= pwdata[1:0];
        zbp_pkg::REG_LX:   lx_r   <= pwdata[15:0];
        zbp_pkg::REG_LY:   ly_r   <= pwdata[15:0];
        zbp_pkg::REG_LZ:   lz_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      zbp_pkg::REG_MODE: prdata = 32'(mode_r);
      zbp_pkg::REG_LX:   prdata = 32'(lx_r);
      zbp_pkg::REG_LY:   prdata = 32'(ly_r);
      zbp_pkg::REG_LZ:   prdata = 32'(lz_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.mode = mode_r;
  assign cfg.lx   = lx_r;
  assign cfg.ly   = ly_r;
  assign cfg.lz   = lz_r;

  assign attr_w[0] = in_attr_0;
  assign attr_w[1] = in_attr_1;
  assign attr_w[2] = in_attr_2;
  assign attr_w[3] = in_attr_3;
  assign attr_w[4] = in_attr_4;
  assign attr_w[5] = in_attr_5;

  // sweep owns the write port until the store is cleared
  assign ram_we    = clr_active || cmd.dwr;
  assign ram_waddr = clr_active ? clr_addr : dp_addr;
  assign ram_wdata = clr_active ? zbp_pkg::DEPTH_FAR : dp_wdata;

  zbp_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_depth (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.drd),
    .raddr(dp_addr),
    .rdata(ram_rdata)
  );

  zbp_ctrl #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd),
    .clr_active(clr_active),
    .clr_addr  (clr_addr)
  );

  zbp_dp #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .in_func        (in_func),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_frag_depth  (in_frag_depth),
    .in_attr        (attr_w),
    .in_front_facing(in_front_facing),
    .addr           (dp_addr),
    .dwdata         (dp_wdata),
    .drdata         (ram_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_write(out_pixel_write),
    .out_x          (out_x),
    .out_row        (out_row),
    .out_argb_color (out_argb_color)
  );

endmodule

// ===== design/zbp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module zbp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/zbp_ctrl.sv =====
// Sequencer: depth-store clearing sweep and per-fragment micro-op schedule.
module zbp_ctrl #(
  parameter int FRAME_WIDTH  = zbp_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = zbp_pkg::FRAME_HEIGHT_DEF,
  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  zbp_pkg::sts_t sts,
  output zbp_pkg::cmd_t cmd,
  output logic          clr_active,
  output logic [AW-1:0] clr_addr
);

  typedef enum logic [20:0] {
    S_CLR  = 21'h000001,
    S_IDLE = 21'h000002,
    S_ADDR = 21'h000004,
    S_RD   = 21'h000008,
    S_TEST = 21'h000010,
    S_SEL  = 21'h000020,
    S_SQ   = 21'h000040,
    S_SQI  = 21'h000080,
    S_SQS  = 21'h000100,
    S_DVI  = 21'h000200,
    S_DVS  = 21'h000400,
    S_DVF  = 21'h000800,
    S_NST  = 21'h001000,
    S_DOT  = 21'h002000,
    S_DCHK = 21'h004000,
    S_DOTH = 21'h008000,
    S_POW  = 21'h010000,
    S_INT0 = 21'h020000,
    S_INT1 = 21'h040000,
    S_COL  = 21'h080000,
    S_EMIT = 21'h100000
  } state_t;

  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [1:0]    lane_r, lane_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [1:0]    pass_r, pass_nxt;
  logic [1:0]    res_r, res_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      lane_r    <= '0;
      step_r    <= '0;
      pass_r    <= zbp_pkg::PASS_OBJ;
      res_r     <= zbp_pkg::RES_ZERO;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      lane_r    <= lane_nxt;
      step_r    <= step_nxt;
      pass_r    <= pass_nxt;
      res_r     <= res_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign clr_addr = clr_cnt_r;

  always_comb begin
    state_nxt   = state_r;
    lane_nxt    = lane_r;
    step_nxt    = step_r;
    pass_nxt    = pass_r;
    res_nxt     = res_r;
    clr_cnt_nxt = clr_cnt_r;
    in_ready    = 1'b0;
    clr_active  = 1'b0;
    cmd         = '0;
    cmd.op      = zbp_pkg::OP_NONE;
    cmd.lane    = lane_r;
    cmd.step    = step_r;
    cmd.pass    = pass_r;
    cmd.res     = res_r;
    unique case (state_r)
      S_CLR: begin
        clr_active  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = zbp_pkg::OP_LOAD;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.op    = zbp_pkg::OP_ADDR;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.drd   = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        lane_nxt = '0;
        pass_nxt = zbp_pkg::PASS_OBJ;
        if (!sts.in_frame) begin
          res_nxt   = zbp_pkg::RES_ZERO;
          state_nxt = S_EMIT;
        end else if (sts.is_clear) begin
          res_nxt   = zbp_pkg::RES_CLEAR;
          state_nxt = S_EMIT;
        end else if (!sts.depth_pass) begin
          res_nxt   = zbp_pkg::RES_ZERO;
          state_nxt = S_EMIT;
        end else if (sts.mode == zbp_pkg::MODE_LIT || sts.mode == zbp_pkg::MODE_NORMAL) begin
          state_nxt = S_SEL;
        end else begin
          state_nxt = S_COL;
        end
      end
      S_SEL: begin
        cmd.op    = zbp_pkg::OP_SEL;
        lane_nxt  = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op   = zbp_pkg::OP_SQ;
        lane_nxt = lane_r + 1'b1;
        if (lane_r == zbp_pkg::LANE_LAST) begin
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.op    = zbp_pkg::OP_SQRT_INIT;
        step_nxt  = '0;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op   = zbp_pkg::OP_SQRT_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == zbp_pkg::SQRT_LAST) begin
          lane_nxt  = '0;
          state_nxt = S_DVI;
        end
      end
      S_DVI: begin
        cmd.op    = zbp_pkg::OP_DIV_INIT;
        step_nxt  = zbp_pkg::DIV_TOP;
        state_nxt = S_DVS;
      end
      S_DVS: begin
        cmd.op   = zbp_pkg::OP_DIV_STEP;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_DVF;
        end
      end
      S_DVF: begin
        cmd.op = zbp_pkg::OP_DIV_FIN;
        if (lane_r == zbp_pkg::LANE_LAST) begin
          state_nxt = S_NST;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_DVI;
        end
      end
      S_NST: begin
        cmd.op   = zbp_pkg::OP_NSTORE;
        lane_nxt = '0;
        step_nxt = '0;
        if (pass_r == zbp_pkg::PASS_OBJ) begin
          pass_nxt  = zbp_pkg::PASS_EYE;
          state_nxt = S_SEL;
        end else if (pass_r == zbp_pkg::PASS_EYE) begin
          state_nxt = (sts.mode == zbp_pkg::MODE_LIT) ? S_DOT : S_COL;
        end else begin
          state_nxt = S_DOTH;
        end
      end
      S_DOT: begin
        cmd.op   = zbp_pkg::OP_DOT;
        lane_nxt = lane_r + 1'b1;
        if (lane_r == zbp_pkg::LANE_LAST) begin
          state_nxt = S_DCHK;
        end
      end
      S_DCHK: begin
        if (sts.dot_pos) begin
          pass_nxt  = zbp_pkg::PASS_HALF;
          state_nxt = S_SEL;
        end else begin
          state_nxt = S_INT0;
        end
      end
      S_DOTH: begin
        cmd.op   = zbp_pkg::OP_DOTH;
        lane_nxt = lane_r + 1'b1;
        if (lane_r == zbp_pkg::LANE_LAST) begin
          step_nxt  = '0;
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        cmd.op   = zbp_pkg::OP_POW;
        step_nxt = step_r + 1'b1;
        if (step_r == zbp_pkg::POW_LAST) begin
          state_nxt = S_INT0;
        end
      end
      S_INT0: begin
        cmd.op    = zbp_pkg::OP_INT0;
        state_nxt = S_INT1;
      end
      S_INT1: begin
        cmd.op    = zbp_pkg::OP_INT1;
        lane_nxt  = '0;
        state_nxt = S_COL;
      end
      S_COL: begin
        cmd.op   = zbp_pkg::OP_COLOR;
        lane_nxt = lane_r + 1'b1;
        if (lane_r == zbp_pkg::LANE_LAST) begin
          res_nxt   = zbp_pkg::RES_COLOR;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.dwr   = (res_r != zbp_pkg::RES_ZERO);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free) else $error("word emitted into a full output register");

  a_dwr_kind: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dwr |-> cmd.emit && (res_r == zbp_pkg::RES_CLEAR || res_r == zbp_pkg::RES_COLOR))
    else $error("depth write without a colour or clear word");

  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active |-> !in_ready && !cmd.dwr) else $error("fragment taken during clearing sweep");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == S_IDLE) else $error("sequencer not idle after emit");

endmodule

// ===== design/zbp_dp.sv =====
// Datapath: fragment registers, shared multiplier, sqrt/divide steps, output word.
module zbp_dp #(
  parameter int FRAME_WIDTH  = zbp_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = zbp_pkg::FRAME_HEIGHT_DEF,
  localparam int AW = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  zbp_pkg::cmd_t      cmd,
  output zbp_pkg::sts_t      sts,
  input  zbp_pkg::cfg_t      cfg,
  input  logic               in_func,
  input  logic [9:0]         in_pixel_x,
  input  logic [9:0]         in_pixel_y,
  input  logic [23:0]        in_frag_depth,
  input  logic signed [23:0] in_attr [6],
  input  logic               in_front_facing,
  output logic [AW-1:0]      addr,
  output logic [23:0]        dwdata,
  input  logic [23:0]        drdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_pixel_write,
  output logic [9:0]         out_x,
  output logic [9:0]         out_row,
  output logic [31:0]        out_argb_color
);

  localparam logic [12:0] W13  = 13'(FRAME_WIDTH);
  localparam logic [12:0] H13  = 13'(FRAME_HEIGHT);
  localparam logic [12:0] HM13 = 13'(FRAME_HEIGHT - 1);

  logic               func_r, func_nxt, ff_r, ff_nxt;
  logic [9:0]         x_r, x_nxt, y_r, y_nxt;
  logic [23:0]        depth_r, depth_nxt;
  logic signed [23:0] a_r [6];
  logic signed [23:0] a_nxt [6];
  logic [AW-1:0]      addr_r, addr_nxt;
  logic signed [24:0] vec_r [3];
  logic signed [24:0] vec_nxt [3];
  logic [47:0]        acc_r, acc_nxt;
  logic [63:0]        sv_r, sv_nxt, sr_r, sr_nxt;
  logic               zero_r, zero_nxt;
  logic [49:0]        rem_r, rem_nxt;
  logic [17:0]        q_r, q_nxt;
  logic signed [15:0] nrm_r [3];
  logic signed [15:0] nrm_nxt [3];
  logic signed [15:0] on_r [3];
  logic signed [15:0] on_nxt [3];
  logic signed [15:0] en_r [3];
  logic signed [15:0] en_nxt [3];
  logic signed [15:0] hn_r [3];
  logic signed [15:0] hn_nxt [3];
  logic signed [33:0] dot_r, dot_nxt, hd_r, hd_nxt;
  logic [14:0]        p_r, p_nxt, p2_r, p2_nxt, p16_r, p16_nxt;
  logic [31:0]        iacc_r, iacc_nxt;
  logic [15:0]        inten_r, inten_nxt;
  logic [7:0]         byte_r [3];
  logic [7:0]         byte_nxt [3];
  logic               out_valid_r, out_valid_nxt;
  logic               wr_r, wr_nxt;
  logic [9:0]         ox_r, ox_nxt, orow_r, orow_nxt;
  logic [31:0]        argb_r, argb_nxt;

  logic signed [15:0] light [3];
  logic signed [25:0] ma, mb;
  logic signed [51:0] prod;
  logic [63:0]        bitv, sq_trial;
  logic [5:0]         bit_sh;
  logic [24:0]        absv;
  logic [49:0]        dv_trial;
  logic [14:0]        mag;
  logic signed [33:0] d14, hd_rnd;
  logic [14:0]        s14, x0;
  logic [51:0]        prnd;
  logic [31:0]        isum;
  logic signed [16:0] ce;
  logic [15:0]        c15;
  logic [29:0]        pl;
  logic [37:0]        tl;
  logic [23:0]        tn;
  logic [16:0]        fv;
  logic [24:0]        tf;
  logic               dot_pos;

  assign light[0] = cfg.lx;
  assign light[1] = cfg.ly;
  assign light[2] = cfg.lz;
  assign dot_pos  = dot_r > 34'sd0;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      zbp_pkg::OP_SQ: begin
        ma = 26'(vec_r[cmd.lane]);
        mb = 26'(vec_r[cmd.lane]);
      end
      zbp_pkg::OP_DOT: begin
        ma = 26'(light[cmd.lane]);
        mb = 26'(en_r[cmd.lane]);
      end
      zbp_pkg::OP_DOTH: begin
        ma = 26'(hn_r[cmd.lane]);
        mb = 26'(en_r[cmd.lane]);
      end
      zbp_pkg::OP_POW: begin
        ma = $signed({11'b0, p_r});
        if (cmd.step == zbp_pkg::POW_M16) begin
          mb = $signed({11'b0, p16_r});
        end else if (cmd.step == zbp_pkg::POW_M2) begin
          mb = $signed({11'b0, p2_r});
        end else begin
          mb = $signed({11'b0, p_r});
        end
      end
      zbp_pkg::OP_INT0: begin
        ma = 26'(zbp_pkg::W_DIFFUSE);
        mb = 26'(d14);
      end
      zbp_pkg::OP_INT1: begin
        ma = 26'(zbp_pkg::W_SPECULAR);
        mb = $signed({11'b0, s14});
      end
      zbp_pkg::OP_COLOR: begin
        ma = $signed({10'b0, c15});
        mb = $signed({10'b0, inten_r});
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  // integer sqrt step: bit walks down two places a step from 2^62
  assign bit_sh   = 6'd62 - {cmd.step, 1'b0};
  assign bitv     = 64'd1 << bit_sh;
  assign sq_trial = sr_r + bitv;

  assign absv     = vec_r[cmd.lane][24] ? 25'(-vec_r[cmd.lane]) : 25'(vec_r[cmd.lane]);
  assign dv_trial = 50'(sr_r[31:0]) << cmd.step;
  assign mag      = zero_r ? 15'd0 : ((q_r > 18'(zbp_pkg::ONE14)) ? 15'(zbp_pkg::ONE14) : q_r[14:0]);

  assign d14    = dot_pos ? ((dot_r + 34'(zbp_pkg::HALF14)) >>> 14) : 34'sd0;
  assign s14    = dot_pos ? p_r : 15'd0;
  assign hd_rnd = (hd_r + 34'(zbp_pkg::HALF14)) >>> 14;
  assign x0     = (hd_r <= 34'sd0) ? 15'd0 :
                  ((hd_rnd > 34'(zbp_pkg::ONE14)) ? 15'(zbp_pkg::ONE14) : hd_rnd[14:0]);
  assign prnd   = prod + 52'(zbp_pkg::HALF14);
  assign isum   = iacc_r + prod[31:0] + 32'(zbp_pkg::HALF14);

  // colour channel terms
  assign ce  = 17'(on_r[cmd.lane]) + 17'(zbp_pkg::ONE14);
  assign c15 = ce[16] ? 16'd0 : ((ce > 17'sd32768) ? 16'd32768 : ce[15:0]);
  assign pl  = (prod > 52'sd536870912) ? 30'd536870912 : prod[29:0];
  assign tl  = (38'(pl) << 8) - 38'(pl) + 38'd268435456;
  assign tn  = (24'(c15) << 8) - 24'(c15) + 24'd16384;
  assign fv  = a_r[cmd.lane][23] ? 17'd0 :
               ((a_r[cmd.lane] > 24'sd65536) ? 17'd65536 : a_r[cmd.lane][16:0]);
  assign tf  = (25'(fv) << 8) - 25'(fv) + 25'd32768;

  always_comb begin
    func_nxt  = func_r;
    ff_nxt    = ff_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    depth_nxt = depth_r;
    addr_nxt  = addr_r;
    acc_nxt   = acc_r;
    sv_nxt    = sv_r;
    sr_nxt    = sr_r;
    zero_nxt  = zero_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    dot_nxt   = dot_r;
    hd_nxt    = hd_r;
    p_nxt     = p_r;
    p2_nxt    = p2_r;
    p16_nxt   = p16_r;
    iacc_nxt  = iacc_r;
    inten_nxt = inten_r;
    for (int i = 0; i < 6; i++) begin
      a_nxt[i] = a_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      vec_nxt[i]  = vec_r[i];
      nrm_nxt[i]  = nrm_r[i];
      on_nxt[i]   = on_r[i];
      en_nxt[i]   = en_r[i];
      hn_nxt[i]   = hn_r[i];
      byte_nxt[i] = byte_r[i];
    end
    case (cmd.op)
      zbp_pkg::OP_LOAD: begin
        func_nxt  = in_func;
        ff_nxt    = in_front_facing;
        x_nxt     = in_pixel_x;
        y_nxt     = in_pixel_y;
        depth_nxt = in_frag_depth;
        for (int i = 0; i < 6; i++) begin
          a_nxt[i] = in_attr[i];
        end
      end
      zbp_pkg::OP_ADDR: begin
        addr_nxt = AW'(32'(y_r) * 32'(FRAME_WIDTH)) + AW'(x_r);
      end
      zbp_pkg::OP_SEL: begin
        if (cmd.pass == zbp_pkg::PASS_OBJ) begin
          for (int i = 0; i < 3; i++) begin
            vec_nxt[i] = 25'(a_r[i]);
          end
        end else if (cmd.pass == zbp_pkg::PASS_EYE) begin
          for (int i = 0; i < 3; i++) begin
            vec_nxt[i] = 25'(a_r[i+3]);
          end
        end else begin
          vec_nxt[0] = 25'(cfg.lx);
          vec_nxt[1] = 25'(cfg.ly);
          vec_nxt[2] = 25'(cfg.lz) + 25'(zbp_pkg::ONE14);
        end
      end
      zbp_pkg::OP_SQ: begin
        acc_nxt = (cmd.lane == '0) ? prod[47:0] : acc_r + prod[47:0];
      end
      zbp_pkg::OP_SQRT_INIT: begin
        sv_nxt   = {acc_r, 16'b0};
        sr_nxt   = '0;
        zero_nxt = (acc_r == '0);
      end
      zbp_pkg::OP_SQRT_STEP: begin
        if (sv_r >= sq_trial) begin
          sv_nxt = sv_r - sq_trial;
          sr_nxt = (sr_r >> 1) + bitv;
        end else begin
          sr_nxt = sr_r >> 1;
        end
      end
      zbp_pkg::OP_DIV_INIT: begin
        // |v| << 22 plus half the divisor for rounding
        rem_nxt = (50'(absv) << 22) + 50'(sr_r[31:1]);
        q_nxt   = '0;
      end
      zbp_pkg::OP_DIV_STEP: begin
        if (rem_r >= dv_trial) begin
          rem_nxt          = rem_r - dv_trial;
          q_nxt[cmd.step] = 1'b1;
        end
      end
      zbp_pkg::OP_DIV_FIN: begin
        nrm_nxt[cmd.lane] = vec_r[cmd.lane][24] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      zbp_pkg::OP_NSTORE: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd.pass == zbp_pkg::PASS_OBJ) begin
            on_nxt[i] = ff_r ? nrm_r[i] : -nrm_r[i];
          end else if (cmd.pass == zbp_pkg::PASS_EYE) begin
            en_nxt[i] = ff_r ? nrm_r[i] : -nrm_r[i];
          end else begin
            hn_nxt[i] = nrm_r[i];
          end
        end
      end
      zbp_pkg::OP_DOT: begin
        dot_nxt = (cmd.lane == '0) ? prod[33:0] : dot_r + prod[33:0];
      end
      zbp_pkg::OP_DOTH: begin
        hd_nxt = (cmd.lane == '0) ? prod[33:0] : hd_r + prod[33:0];
      end
      zbp_pkg::OP_POW: begin
        if (cmd.step == '0) begin
          p_nxt = x0;
        end else begin
          p_nxt = prnd[28:14];
          if (cmd.step == zbp_pkg::POW_P2) begin
            p2_nxt = prnd[28:14];
          end
          if (cmd.step == zbp_pkg::POW_P16) begin
            p16_nxt = prnd[28:14];
          end
        end
      end
      zbp_pkg::OP_INT0: begin
        iacc_nxt = prod[31:0];
      end
      zbp_pkg::OP_INT1: begin
        inten_nxt = isum[29:14];
      end
      zbp_pkg::OP_COLOR: begin
        if (cfg.mode == zbp_pkg::MODE_LIT) begin
          byte_nxt[cmd.lane] = tl[36:29];
        end else if (cfg.mode == zbp_pkg::MODE_NORMAL) begin
          byte_nxt[cmd.lane] = tn[22:15];
        end else begin
          byte_nxt[cmd.lane] = tf[23:16];
        end
      end
      default: ;
    endcase
  end

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    wr_nxt        = wr_r;
    ox_nxt        = ox_r;
    orow_nxt      = orow_r;
    argb_nxt      = argb_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (cmd.res == zbp_pkg::RES_ZERO) begin
        wr_nxt   = 1'b0;
        ox_nxt   = '0;
        orow_nxt = '0;
        argb_nxt = '0;
      end else begin
        wr_nxt   = 1'b1;
        ox_nxt   = x_r;
        orow_nxt = 10'(HM13 - 13'(y_r));
        argb_nxt = (cmd.res == zbp_pkg::RES_CLEAR) ? zbp_pkg::ALPHA_OPAQUE :
                   {zbp_pkg::ALPHA_BYTE, byte_r[0], byte_r[1], byte_r[2]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    ff_r    <= ff_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    depth_r <= depth_nxt;
    addr_r  <= addr_nxt;
    acc_r   <= acc_nxt;
    sv_r    <= sv_nxt;
    sr_r    <= sr_nxt;
    zero_r  <= zero_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    dot_r   <= dot_nxt;
    hd_r    <= hd_nxt;
    p_r     <= p_nxt;
    p2_r    <= p2_nxt;
    p16_r   <= p16_nxt;
    iacc_r  <= iacc_nxt;
    inten_r <= inten_nxt;
    wr_r    <= wr_nxt;
    ox_r    <= ox_nxt;
    orow_r  <= orow_nxt;
    argb_r  <= argb_nxt;
    for (int i = 0; i < 6; i++) begin
      a_r[i] <= a_nxt[i];
    end
    for (int i = 0; i < 3; i++) begin
      vec_r[i]  <= vec_nxt[i];
      nrm_r[i]  <= nrm_nxt[i];
      on_r[i]   <= on_nxt[i];
      en_r[i]   <= en_nxt[i];
      hn_r[i]   <= hn_nxt[i];
      byte_r[i] <= byte_nxt[i];
    end
  end

  assign addr   = addr_r;
  assign dwdata = (cmd.res == zbp_pkg::RES_CLEAR) ? zbp_pkg::DEPTH_FAR : depth_r;

  assign sts.in_frame   = (13'(x_r) < W13) && (13'(y_r) < H13);
  assign sts.is_clear   = func_r;
  assign sts.depth_pass = depth_r < drdata;
  assign sts.dot_pos    = dot_pos;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.mode       = cfg.mode;

  assign out_valid       = out_valid_r;
  assign out_pixel_write = wr_r;
  assign out_x           = ox_r;
  assign out_row         = orow_r;
  assign out_argb_color  = argb_r;

endmodule
